>>> rtl/cdq_pkg.sv
`default_nettype none

package cdq_pkg;

    localparam int WORD_W = 32;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_REAR   = 3'd3;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SHIFT_IN,
        OP_SHIFT_OUT,
        OP_APPEND,
        OP_TRIM
    } cell_op_t;

    typedef struct packed {
        logic     clear;
        cell_op_t op;
        word_t    value;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SEND
    } state_t;

endpackage

`default_nettype wire

>>> rtl/circular_deque.sv
// Double-ended queue of signed 32-bit words with a configurable capacity.
// Requests arrive on in_valid/in_ready with command and value; each request
// yields exactly one result on out_valid/out_ready: ok, front_item,
// rear_item, is_empty and is_full, all as they stand after the command.
// Empty queue reports -1 for both front_item and rear_item.
// Storage is a row of DEPTH cells; cell 0 holds the front entry. A front
// insert or front removal shifts the whole row by one cell;
// rear operations touch only the boundary cell.
// The cells and ok update at the accepting edge; the LOAD state then
// copies the updated cells into the result registers, and the SEND state
// presents the result on out_valid.
// A new request is not taken before the previous result is taken; the
// next request is taken in the cycle its predecessor's result is taken.
// When the receiver stalls, the result holds and in_ready stays low.
// Reset empties the queue and sets the capacity to 16. A write on
// cfg_wen/cfg_data sets the capacity (0 acts as 1, values above DEPTH
// act as DEPTH) and empties the queue; write it only while idle.
`default_nettype none

module circular_deque #(
    parameter int DEPTH = 16
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_wen,
    input  wire [cdq_pkg::CAP_W-1:0]      cfg_data,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire [2:0]                     command,
    input  cdq_pkg::word_t                value,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic                          ok,
    output cdq_pkg::word_t                front_item,
    output cdq_pkg::word_t                rear_item,
    output logic                          is_empty,
    output logic                          is_full
);
    import cdq_pkg::*;

    localparam int DW = $clog2(DEPTH + 1);
    localparam int CW = (DW > CAP_W) ? DW : CAP_W;

    state_t state_reg;
    state_t state_next;

    logic [CAP_W-1:0] capacity_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [CW-1:0]    cap_ext;
    logic [CW-1:0]    size;

    logic  ok_reg;
    logic  ok_next;
    word_t front_reg;
    word_t rear_reg;
    logic  empty_reg;
    logic  full_reg;

    logic       in_fire;
    logic       load_en;
    cell_ctrl_t ctrl;

    word_t cell_data  [DEPTH];
    word_t left_data  [DEPTH];
    word_t right_data [DEPTH];
    logic [DEPTH:0] valid_ext;
    logic [DEPTH-1:0] left_valid;
    word_t rear_any;
    logic  at_full;
    logic  at_empty;

    assign cap_ext = CW'(capacity_reg);

    always_comb
    begin
        if (cap_ext == '0)
        begin
            size = CW'(1);
        end
        else if (cap_ext > CW'(DEPTH))
        begin
            size = CW'(DEPTH);
        end
        else
        begin
            size = cap_ext;
        end
    end

    assign at_full  = (count_reg == size);
    assign at_empty = (count_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_ready)
                begin
                    state_next = in_valid ? ST_LOAD : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the controller
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        load_en   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_LOAD:
            begin
                load_en = 1'b1;
            end
            ST_SEND:
            begin
                out_valid = 1'b1;
                in_ready  = out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign in_fire = in_valid && in_ready;

    // decode the request into one row-wide operation
    always_comb
    begin
        ctrl.clear = cfg_wen;
        ctrl.op    = OP_HOLD;
        ctrl.value = value;
        ok_next    = 1'b1;
        count_next = count_reg;
        if (in_fire)
        begin
            case (command)
                CMD_PUSH_FRONT:
                begin
                    ok_next = !at_full;
                    if (!at_full)
                    begin
                        ctrl.op    = OP_SHIFT_IN;
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_PUSH_REAR:
                begin
                    ok_next = !at_full;
                    if (!at_full)
                    begin
                        ctrl.op    = OP_APPEND;
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_POP_FRONT:
                begin
                    ok_next = !at_empty;
                    if (!at_empty)
                    begin
                        ctrl.op    = OP_SHIFT_OUT;
                        count_next = count_reg - CW'(1);
                    end
                end
                CMD_POP_REAR:
                begin
                    ok_next = !at_empty;
                    if (!at_empty)
                    begin
                        ctrl.op    = OP_TRIM;
                        count_next = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    ok_next = 1'b1;
                end
            endcase
        end
        if (cfg_wen)
        begin
            count_next = '0;
        end
    end

    assign valid_ext[DEPTH] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign left_data[gi]  = value;
                assign left_valid[gi] = 1'b1;
            end
            else
            begin : g_body
                assign left_data[gi]  = cell_data[gi-1];
                assign left_valid[gi] = valid_ext[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_tail
                assign right_data[gi] = '0;
            end
            else
            begin : g_inner
                assign right_data[gi] = cell_data[gi+1];
            end

            cdq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .left_data   (left_data[gi]),
                .left_valid  (left_valid[gi]),
                .right_data  (right_data[gi]),
                .right_valid (valid_ext[gi+1]),
                .data        (cell_data[gi]),
                .valid       (valid_ext[gi])
            );
        end
    endgenerate

    // the rear is the one occupied cell whose right neighbor is free
    always_comb
    begin
        rear_any = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (valid_ext[i] && !valid_ext[i+1])
            begin
                rear_any = rear_any | cell_data[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            capacity_reg <= CAP_RESET;
            count_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_wen)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ok_reg <= ok_next;
        end
        if (load_en)
        begin
            front_reg <= valid_ext[0] ? cell_data[0] : word_t'(-1);
            rear_reg  <= valid_ext[0] ? rear_any : word_t'(-1);
            empty_reg <= !valid_ext[0];
            full_reg  <= at_full;
        end
    end

    assign ok         = ok_reg;
    assign front_item = front_reg;
    assign rear_item  = rear_reg;
    assign is_empty   = empty_reg;
    assign is_full    = full_reg;

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= size)
        else $error("entry count above active size");

    a_front_cell_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        valid_ext[0] == (count_reg != '0))
        else $error("front cell occupancy disagrees with entry count");

    a_load_then_send: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOAD |=> out_valid)
        else $error("result not presented after load");

    a_accept_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == ST_LOAD)
        else $error("accepted request not processed");

    a_not_empty_and_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_empty && is_full))
        else $error("result reports empty and full together");

endmodule

`default_nettype wire

>>> rtl/cdq_cell.sv
`default_nettype none

module cdq_cell (
    input  wire                 clk,
    input  wire                 rst_n,
    input  cdq_pkg::cell_ctrl_t ctrl,
    input  cdq_pkg::word_t      left_data,
    input  wire                 left_valid,
    input  cdq_pkg::word_t      right_data,
    input  wire                 right_valid,
    output cdq_pkg::word_t      data,
    output logic                valid
);
    import cdq_pkg::*;

    word_t data_reg;
    word_t data_next;
    logic  valid_reg;
    logic  valid_next;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        case (ctrl.op)
            OP_HOLD:
            begin
                data_next  = data_reg;
            end
            OP_SHIFT_IN:
            begin
                data_next  = left_data;
                valid_next = left_valid;
            end
            OP_SHIFT_OUT:
            begin
                data_next  = right_data;
                valid_next = right_valid;
            end
            OP_APPEND:
            begin
                // first free cell takes the word
                if (!valid_reg && left_valid)
                begin
                    data_next  = ctrl.value;
                    valid_next = 1'b1;
                end
            end
            OP_TRIM:
            begin
                // drop the last occupied cell
                if (valid_reg && !right_valid)
                begin
                    valid_next = 1'b0;
                end
            end
            default:
            begin
                data_next  = data_reg;
            end
        endcase
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

>>> tb/tb_circular_deque.sv
`timescale 1ns / 100ps

module tb_circular_deque;
    import cdq_pkg::*;

    localparam int DEPTH = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int SEGMENT_ITEMS = 150;

    localparam logic [2:0] CMD_QUERY  = 3'd4;
    localparam logic [2:0] CMD_RSVD_5 = 3'd5;
    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;

    localparam logic ROW_REQ = 1'b0;
    localparam logic ROW_CAP = 1'b1;

    localparam logic [31:0] NONE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic  ok;
        word_t front;
        word_t rear;
        logic  empty;
        logic  full;
    } deque_result_t;

    typedef struct packed {
        logic             kind;
        logic [CAP_W-1:0] cap;
        logic [2:0]       cmd;
        word_t            word;
        logic             pinned;
        logic             ok;
        word_t            front;
        word_t            rear;
        logic             empty;
        logic             full;
    } plan_row_t;

    localparam int PLAN_LEN = 28;

    // Rows with pinned = 1 carry the expected result typed in directly.
    plan_row_t plan [PLAN_LEN] = '{
        '{ROW_REQ, 5'd0,  CMD_QUERY,      32'h0000_0000, 1'b1, 1'b1, NONE, NONE, 1'b1, 1'b0},
        '{ROW_REQ, 5'd0,  CMD_POP_FRONT,  32'h0000_0000, 1'b1, 1'b0, NONE, NONE, 1'b1, 1'b0},
        '{ROW_REQ, 5'd0,  CMD_POP_REAR,   32'h0000_0000, 1'b1, 1'b0, NONE, NONE, 1'b1, 1'b0},
        '{ROW_REQ, 5'd0,  CMD_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1, 1'b1,
          32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0},
        '{ROW_REQ, 5'd0,  CMD_POP_REAR,   32'h0000_0000, 1'b1, 1'b1, NONE, NONE, 1'b1, 1'b0},
        '{ROW_REQ, 5'd0,  CMD_PUSH_REAR,  32'h8000_0000, 1'b1, 1'b1,
          32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0},
        '{ROW_REQ, 5'd0,  CMD_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, 1'b1,
          32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 1'b0},
        '{ROW_REQ, 5'd0,  CMD_PUSH_REAR,  32'h0000_0000, 1'b1, 1'b1,
          32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0},
        '{ROW_REQ, 5'd0,  CMD_RSVD_5,     32'h1234_5678, 1'b1, 1'b1,
          32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0},
        '{ROW_REQ, 5'd0,  CMD_RSVD_6,     32'h8765_4321, 1'b1, 1'b1,
          32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0},
        '{ROW_REQ, 5'd0,  CMD_RSVD_7,     32'hFFFF_FFFF, 1'b1, 1'b1,
          32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0},
        '{ROW_REQ, 5'd0,  CMD_POP_FRONT,  32'h0000_0000, 1'b1, 1'b1,
          32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0},
        '{ROW_REQ, 5'd0,  CMD_POP_REAR,   32'h0000_0000, 1'b1, 1'b1,
          32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0},
        '{ROW_REQ, 5'd0,  CMD_POP_FRONT,  32'h0000_0000, 1'b1, 1'b1, NONE, NONE, 1'b1, 1'b0},
        '{ROW_CAP, 5'd2,  CMD_QUERY,      32'h0000_0000, 1'b0, 1'b0, NONE, NONE, 1'b0, 1'b0},
        '{ROW_REQ, 5'd0,  CMD_PUSH_FRONT, 32'h5555_5555, 1'b1, 1'b1,
          32'h5555_5555, 32'h5555_5555, 1'b0, 1'b0},
        '{ROW_REQ, 5'd0,  CMD_PUSH_FRONT, 32'hAAAA_AAAA, 1'b1, 1'b1,
          32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b1},
        '{ROW_REQ, 5'd0,  CMD_PUSH_REAR,  32'h0000_0001, 1'b1, 1'b0,
          32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b1},
        '{ROW_REQ, 5'd0,  CMD_PUSH_FRONT, 32'h0000_0001, 1'b1, 1'b0,
          32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b1},
        '{ROW_REQ, 5'd0,  CMD_POP_FRONT,  32'h0000_0000, 1'b1, 1'b1,
          32'h5555_5555, 32'h5555_5555, 1'b0, 1'b0},
        '{ROW_REQ, 5'd0,  CMD_PUSH_REAR,  32'h0F0F_0F0F, 1'b0, 1'b0, NONE, NONE, 1'b0, 1'b0},
        // zero capacity acts as one slot
        '{ROW_CAP, 5'd0,  CMD_QUERY,      32'h0000_0000, 1'b0, 1'b0, NONE, NONE, 1'b0, 1'b0},
        '{ROW_REQ, 5'd0,  CMD_PUSH_REAR,  32'h0000_007B, 1'b1, 1'b1,
          32'h0000_007B, 32'h0000_007B, 1'b0, 1'b1},
        '{ROW_REQ, 5'd0,  CMD_PUSH_FRONT, 32'h0000_0009, 1'b1, 1'b0,
          32'h0000_007B, 32'h0000_007B, 1'b0, 1'b1},
        '{ROW_REQ, 5'd0,  CMD_POP_FRONT,  32'h0000_0000, 1'b1, 1'b1, NONE, NONE, 1'b1, 1'b0},
        '{ROW_REQ, 5'd0,  CMD_QUERY,      32'h0000_0000, 1'b0, 1'b0, NONE, NONE, 1'b0, 1'b0},
        // above the built depth saturates
        '{ROW_CAP, 5'd31, CMD_QUERY,      32'h0000_0000, 1'b0, 1'b0, NONE, NONE, 1'b0, 1'b0},
        '{ROW_REQ, 5'd0,  CMD_PUSH_REAR,  32'hDEAD_BEEF, 1'b0, 1'b0, NONE, NONE, 1'b0, 1'b0}
    };

    localparam int CAP_PLAN_LEN = 10;

    logic [CAP_W-1:0] cap_plan [CAP_PLAN_LEN] = '{
        5'd1, 5'd16, 5'd3, 5'd0, 5'd31, 5'd7, 5'd17, 5'd2, 5'd16, 5'd10
    };

    logic             clk;
    logic             rst_n;
    logic             cfg_wen;
    logic [CAP_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_ready;
    logic [2:0]       command;
    word_t            value;
    logic             out_valid;
    logic             out_ready;
    logic             ok;
    word_t            front_item;
    word_t            rear_item;
    logic             is_empty;
    logic             is_full;

    // request side tags, move with the payload
    logic          req_pinned;
    deque_result_t req_want;

    int send_idle_pct;
    int recv_idle_pct;
    int mismatch_count;
    int result_count;
    int stall_cycles;

    deque_result_t due_results [$];

    // mirror of the deque
    logic [31:0] ring_slot [DEPTH];
    int          ring_size;
    int          ring_head;
    int          ring_tail;
    logic        ring_empty;

    circular_deque #(
        .DEPTH(DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ok        (ok),
        .front_item(front_item),
        .rear_item (rear_item),
        .is_empty  (is_empty),
        .is_full   (is_full)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int wrap_up(int p);
        return (p + 1 >= ring_size) ? 0 : p + 1;
    endfunction

    function automatic int wrap_down(int p);
        return (p == 0) ? ring_size - 1 : p - 1;
    endfunction

    function automatic logic ring_full();
        return !ring_empty && (wrap_up(ring_tail) == ring_head);
    endfunction

    function automatic deque_result_t apply_command(logic [2:0] cmd, word_t word);
        deque_result_t r;
        r.ok = 1'b1;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_REAR:
            begin
                if (ring_full())
                begin
                    r.ok = 1'b0;
                end
                else if (cmd == CMD_PUSH_FRONT)
                begin
                    if (!ring_empty)
                        ring_head = wrap_down(ring_head);
                    ring_slot[ring_head] = word;
                    ring_empty = 1'b0;
                end
                else
                begin
                    if (!ring_empty)
                        ring_tail = wrap_up(ring_tail);
                    ring_slot[ring_tail] = word;
                    ring_empty = 1'b0;
                end
            end
            CMD_POP_FRONT, CMD_POP_REAR:
            begin
                if (ring_empty)
                    r.ok = 1'b0;
                else if (ring_head == ring_tail)
                    ring_empty = 1'b1;  // last entry: pointers stay put
                else if (cmd == CMD_POP_FRONT)
                    ring_head = wrap_up(ring_head);
                else
                    ring_tail = wrap_down(ring_tail);
            end
            default:
            begin
            end
        endcase
        r.front = ring_empty ? NONE : ring_slot[ring_head];
        r.rear  = ring_empty ? NONE : ring_slot[ring_tail];
        r.empty = ring_empty;
        r.full  = ring_full();
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatch_count < 100)
            $display("%0t: result %0d %s: got %h, expected %h",
                     $realtime, result_count, what, got, want);
        mismatch_count++;
    endtask

    // track config, predict accepted requests, check results
    always @(posedge clk)
    begin
        deque_result_t got;
        deque_result_t want;
        deque_result_t model;
        if (rst_n)
        begin
            if (cfg_wen)
            begin
                ring_size  = (cfg_data == '0) ? 1 :
                             (int'(cfg_data) > DEPTH) ? DEPTH : int'(cfg_data);
                ring_head  = 0;
                ring_tail  = 0;
                ring_empty = 1'b1;
            end
            if (in_valid && in_ready)
            begin
                model = apply_command(command, value);
                due_results.push_back(req_pinned ? req_want : model);
            end
            if (out_valid && out_ready)
            begin
                got = {ok, front_item, rear_item, is_empty, is_full};
                if (due_results.size() == 0)
                begin
                    report_mismatch("arrived with nothing pending", got.front, NONE);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.ok !== want.ok)
                        report_mismatch("ok", 32'(got.ok), 32'(want.ok));
                    if (got.front !== want.front)
                        report_mismatch("front_item", got.front, want.front);
                    if (got.rear !== want.rear)
                        report_mismatch("rear_item", got.rear, want.rear);
                    if (got.empty !== want.empty)
                        report_mismatch("is_empty", 32'(got.empty), 32'(want.empty));
                    if (got.full !== want.full)
                        report_mismatch("is_full", 32'(got.full), 32'(want.full));
                end
                result_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_request(logic [2:0] cmd, word_t word, logic pin, deque_result_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        value      <= word;
        req_pinned <= pin;
        req_want   <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // hold off new requests until every result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (due_results.size() != 0);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        drain_results();
        repeat (4) @(posedge clk);
        cfg_wen  <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    initial
    begin
        logic [2:0] cmd;
        word_t      word;
        int         push_pct;
        int         roll;
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_wen        = 1'b0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        command        = CMD_QUERY;
        value          = '0;
        out_ready      = 1'b0;
        req_pinned     = 1'b0;
        req_want       = '0;
        mismatch_count = 0;
        result_count   = 0;
        stall_cycles   = 0;
        ring_size      = DEPTH;
        ring_head      = 0;
        ring_tail      = 0;
        ring_empty     = 1'b1;
        push_pct       = 50;
        foreach (ring_slot[i])
            ring_slot[i] = '0;
        send_idle_pct = 14;
        recv_idle_pct = 57;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (plan[i].kind == ROW_CAP)
                write_capacity(plan[i].cap);
            else
                send_request(plan[i].cmd, plan[i].word, plan[i].pinned,
                             {plan[i].ok, plan[i].front, plan[i].rear,
                              plan[i].empty, plan[i].full});
        end

        for (int s = 0; s < CAP_PLAN_LEN; s++)
        begin
            if (s < 4)
            begin
                send_idle_pct = 14;
                recv_idle_pct = 57;
            end
            else if (s < 7)
            begin
                send_idle_pct = 57;
                recv_idle_pct = 14;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_capacity(cap_plan[s]);
            for (int n = 0; n < SEGMENT_ITEMS; n++)
            begin
                // swing between filling and draining so full and empty both occur
                if (n % 16 == 0)
                    push_pct = ($urandom_range(2) == 0) ? 25 :
                               ($urandom_range(1) == 0) ? 50 : 80;
                roll = $urandom_range(99);
                if (roll < 4)
                    cmd = CMD_QUERY;
                else if (roll < 7)
                    cmd = 3'($urandom_range(CMD_RSVD_7, CMD_RSVD_5));
                else if ($urandom_range(99) < push_pct)
                    cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
                else
                    cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_REAR;
                case ($urandom_range(9))
                    0: word = 32'h8000_0000;
                    1: word = 32'h7FFF_FFFF;
                    2: word = 32'hFFFF_FFFF;
                    3: word = 32'h0000_0000;
                    default: word = $urandom;
                endcase
                if ($urandom_range(99) == 0)
                    drain_results();
                send_request(cmd, word, 1'b0, '0);
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
